// ----- hdl/pra_pkg.sv -----
// Shared types, codes and default sizes for the page run allocator.
// Used by pra_mark_mem, pra_ctrl and page_run_allocator_top; depends on nothing.
`default_nettype none

package pra_pkg;

    // Default store geometry.
    localparam int DEF_NUM_PAGES      = 1024;
    localparam int DEF_RESERVED_PAGES = 1;

    // Field widths of the request and result beats.
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int FIRST_W  = 10;

    // Configuration port.
    localparam int CFG_W      = 11;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_SEARCH_STARTS = 2'd0;

    // Per-page marks.
    localparam int MARK_W         = 2;
    localparam int MARK_TAKEN_BIT = 0;
    localparam int MARK_LAST_BIT  = 1;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOSPACE  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RESERVED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DOUBLE   = 3'd4;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_PREV,
        S_WALK
    } ctrl_state_t;

    // Result beat from the sequencer to the top level.
    typedef struct packed {
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [FIRST_W-1:0]  first_page;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/pra_mark_mem.sv -----
// Page mark store: one two-bit entry per page, one write and one read port.
// Read data is registered. Depends on pra_pkg.
`default_nettype none

module pra_mark_mem #(
    parameter int NUM_PAGES = pra_pkg::DEF_NUM_PAGES
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(NUM_PAGES)-1:0] rd_addr,
    output logic      [pra_pkg::MARK_W-1:0]   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(NUM_PAGES)-1:0] wr_addr,
    input  wire logic [pra_pkg::MARK_W-1:0]   wr_data
);
    import pra_pkg::*;

    logic [MARK_W-1:0] mark_ram [NUM_PAGES];
    logic [MARK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mark_ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/pra_ctrl.sv -----
// Sequencer for the page run allocator: clearing pass, first-fit scan,
// run marking and free walk over the mark store. Depends on pra_pkg.
`default_nettype none

module pra_ctrl #(
    parameter int NUM_PAGES      = pra_pkg::DEF_NUM_PAGES,
    parameter int RESERVED_PAGES = pra_pkg::DEF_RESERVED_PAGES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         req_type,
    input  wire logic [pra_pkg::COUNT_W-1:0]  page_count,
    input  wire logic [pra_pkg::INDEX_W-1:0]  page_index,
    input  wire logic [pra_pkg::CFG_W-1:0]    search_starts,
    output logic                              busy,
    output logic                              mem_rd_en,
    output logic      [$clog2(NUM_PAGES)-1:0] mem_rd_addr,
    input  wire logic [pra_pkg::MARK_W-1:0]   mem_rd_data,
    output logic                              mem_wr_en,
    output logic      [$clog2(NUM_PAGES)-1:0] mem_wr_addr,
    output logic      [pra_pkg::MARK_W-1:0]   mem_wr_data,
    output pra_pkg::result_t                  res
);
    import pra_pkg::*;

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int PTR_W  = PAGE_W + 1;
    localparam int CMP_W  = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;

    ctrl_state_t         state_reg, state_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [PTR_W-1:0]    ev_addr_reg, ev_addr_next;
    logic [PAGE_W-1:0]   run_start_reg, run_start_next;
    logic [COUNT_W-1:0]  run_len_reg, run_len_next;
    logic [COUNT_W-1:0]  need_reg, need_next;
    logic [PAGE_W-1:0]   loc_reg, loc_next;
    result_t             res_reg, res_next;

    logic                taken;
    logic                last;
    logic                at_end;
    logic                beyond_win;
    logic [CMP_W-1:0]    idx_ext;
    logic [COUNT_W-1:0]  len_inc;
    logic [PAGE_W-1:0]   cand_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            ptr_reg      <= '0;
            ev_valid_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            ev_valid_reg <= ev_valid_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_addr_reg   <= ev_addr_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        need_reg      <= need_next;
        loc_reg       <= loc_next;
    end

    assign taken      = mem_rd_data[MARK_TAKEN_BIT];
    assign last       = mem_rd_data[MARK_LAST_BIT];
    assign at_end     = (ev_addr_reg == PTR_W'(NUM_PAGES - 1));
    assign beyond_win = (CMP_W'(ev_addr_reg) >= CMP_W'(search_starts));
    assign idx_ext    = CMP_W'(page_index);
    assign len_inc    = run_len_reg + COUNT_W'(1);
    assign cand_start = (run_len_reg == '0) ? ev_addr_reg[PAGE_W-1:0] : run_start_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        ev_valid_next  = 1'b0;
        ev_addr_next   = ptr_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        need_next      = need_reg;
        loc_next       = loc_reg;
        res_next       = res_reg;
        res_next.done  = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = ptr_reg[PAGE_W-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = ev_addr_reg[PAGE_W-1:0];
        mem_wr_data    = '0;

        // Scan and walk stream one read per cycle; the data returns in the next cycle.
        if ((state_reg == S_SCAN || state_reg == S_WALK) && ptr_reg < PTR_W'(NUM_PAGES))
        begin
            mem_rd_en     = 1'b1;
            ev_valid_next = 1'b1;
            ev_addr_next  = ptr_reg;
            ptr_next      = ptr_reg + PTR_W'(1);
        end

        case (state_reg)
            S_INIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg[PAGE_W-1:0];
                mem_wr_data[MARK_TAKEN_BIT] = CMP_W'(ptr_reg) < CMP_W'(RESERVED_PAGES);
                mem_wr_data[MARK_LAST_BIT]  = CMP_W'(ptr_reg) == CMP_W'(RESERVED_PAGES - 1);
                if (ptr_reg == PTR_W'(NUM_PAGES - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_ALLOC)
                    begin
                        need_next     = (page_count == '0) ? COUNT_W'(1) : page_count;
                        run_len_next  = '0;
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = '0;
                        ev_valid_next = 1'b1;
                        ev_addr_next  = '0;
                        ptr_next      = PTR_W'(1);
                        state_next    = S_SCAN;
                    end
                    else if (idx_ext >= CMP_W'(NUM_PAGES))
                    begin
                        res_next = '{done: 1'b1, status: STAT_RANGE, first_page: '0};
                    end
                    else if (idx_ext < CMP_W'(RESERVED_PAGES))
                    begin
                        res_next = '{done: 1'b1, status: STAT_RESERVED, first_page: '0};
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = PAGE_W'(idx_ext - CMP_W'(1));
                        loc_next    = PAGE_W'(idx_ext);
                        state_next  = S_PREV;
                    end
                end
            end

            S_SCAN:
            begin
                if (ev_valid_reg)
                begin
                    if (taken)
                    begin
                        run_len_next = '0;
                        if (beyond_win || at_end)
                        begin
                            res_next   = '{done: 1'b1, status: STAT_NOSPACE, first_page: '0};
                            state_next = S_IDLE;
                        end
                    end
                    else if (run_len_reg == '0 && beyond_win)
                    begin
                        res_next   = '{done: 1'b1, status: STAT_NOSPACE, first_page: '0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        run_start_next = cand_start;
                        if (len_inc == need_reg)
                        begin
                            // Run found: mark it, counting down from the run length.
                            ptr_next     = PTR_W'(cand_start);
                            run_len_next = need_reg;
                            state_next   = S_MARK;
                        end
                        else
                        begin
                            run_len_next = len_inc;
                            if (at_end)
                            begin
                                res_next   = '{done: 1'b1, status: STAT_NOSPACE,
                                               first_page: '0};
                                state_next = S_IDLE;
                            end
                        end
                    end
                end
            end

            S_MARK:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg[PAGE_W-1:0];
                mem_wr_data[MARK_TAKEN_BIT] = 1'b1;
                mem_wr_data[MARK_LAST_BIT]  = (run_len_reg == COUNT_W'(1));
                ptr_next     = ptr_reg + PTR_W'(1);
                run_len_next = run_len_reg - COUNT_W'(1);
                if (run_len_reg == COUNT_W'(1))
                begin
                    res_next   = '{done: 1'b1, status: STAT_OK,
                                   first_page: FIRST_W'(run_start_reg)};
                    state_next = S_IDLE;
                end
            end

            S_PREV:
            begin
                // The page before the freed one closes its own run if taken.
                if (taken)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = loc_reg - PAGE_W'(1);
                    mem_wr_data[MARK_TAKEN_BIT] = 1'b1;
                    mem_wr_data[MARK_LAST_BIT]  = 1'b1;
                end
                mem_rd_en     = 1'b1;
                mem_rd_addr   = loc_reg;
                ev_valid_next = 1'b1;
                ev_addr_next  = PTR_W'(loc_reg);
                ptr_next      = PTR_W'(loc_reg) + PTR_W'(1);
                state_next    = S_WALK;
            end

            S_WALK:
            begin
                if (ev_valid_reg)
                begin
                    if (!taken)
                    begin
                        res_next   = '{done: 1'b1, status: STAT_DOUBLE, first_page: '0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // A free page always holds both marks clear.
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = ev_addr_reg[PAGE_W-1:0];
                        mem_wr_data = '0;
                        if (last || at_end)
                        begin
                            res_next   = '{done: 1'b1, status: STAT_OK, first_page: '0};
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

endmodule

`default_nettype wire

// ----- hdl/page_run_allocator_top.sv -----
// Top level of the page run allocator: configuration registers, mark store and
// sequencer. Depends on pra_pkg, pra_mark_mem and pra_ctrl.
`default_nettype none

// Page run allocator. Each page carries a taken mark and a last-of-run mark,
// held in a single-port-read, single-port-write RAM of NUM_PAGES two-bit
// entries. A request beat is taken when start is high and busy is low. An
// allocate beat searches first fit for page_count free pages (zero means one)
// whose first page lies below the search_starts register, marks the run and
// returns its first page. A free beat closes the run of the page in front
// (if taken) and then clears pages up to the next last-marked page. Every
// request produces exactly one result beat: done is high for one cycle with
// status and first_page valid, and the receiver must take it then, because
// the block cannot hold a result back. done appears in the same cycle that
// busy falls, so a new request may be issued at once.
// Timing: the sequencer walks the RAM one page per cycle. An allocate stays
// busy while it examines pages and marks the pages granted, where the pages
// examined run from page 0 to the page where the search ends; a failed search
// stops at the first page at or beyond the window that cannot extend a run,
// or at the last page of the store if it gets there first.
// A free stays busy while it checks the page in front and walks its run.
// Out-of-range and reserved-page frees answer in the cycle after acceptance
// without going busy. After reset a clearing pass initializes all NUM_PAGES
// RAM entries, with busy high; configuration writes are taken throughout.
// search_starts sits at byte address 0 of the APB-style port and resets to
// one tenth of NUM_PAGES. Configuration may only change while busy is low and
// no request is in flight.

module page_run_allocator_top #(
    parameter int NUM_PAGES      = pra_pkg::DEF_NUM_PAGES,
    parameter int RESERVED_PAGES = pra_pkg::DEF_RESERVED_PAGES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              req_type,
    input  wire logic [pra_pkg::COUNT_W-1:0]       page_count,
    input  wire logic [pra_pkg::INDEX_W-1:0]       page_index,
    output logic                                   done,
    output logic      [pra_pkg::STATUS_W-1:0]      status,
    output logic      [pra_pkg::FIRST_W-1:0]       first_page,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pra_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [pra_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [pra_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import pra_pkg::*;

    localparam int PAGE_W = $clog2(NUM_PAGES);

    logic [CFG_W-1:0]  search_starts_reg;
    logic              cfg_wr;
    logic              mem_rd_en;
    logic [PAGE_W-1:0] mem_rd_addr;
    logic [MARK_W-1:0] mem_rd_data;
    logic              mem_wr_en;
    logic [PAGE_W-1:0] mem_wr_addr;
    logic [MARK_W-1:0] mem_wr_data;
    result_t           res;

    // Configuration port: writes land in the access phase, reads are direct.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_SEARCH_STARTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_starts_reg <= CFG_W'(NUM_PAGES / 10);
        end
        else if (cfg_wr)
        begin
            search_starts_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_SEARCH_STARTS)
        begin
            prdata = APB_DATA_W'(search_starts_reg);
        end
    end

    pra_mark_mem #(
        .NUM_PAGES (NUM_PAGES)
    ) u_mark_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    pra_ctrl #(
        .NUM_PAGES      (NUM_PAGES),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .req_type      (req_type),
        .page_count    (page_count),
        .page_index    (page_index),
        .search_starts (search_starts_reg),
        .busy          (busy),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .res           (res)
    );

    assign done       = res.done;
    assign status     = res.status;
    assign first_page = res.first_page;

    // A failed request never reports a page.
    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (first_page == '0))
        else $error("failed request reported a nonzero first page");

    // An allocate always enters the scan, so the block is busy next cycle.
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_ALLOC) |=> busy)
        else $error("allocate did not start a scan");

    // An out-of-range free answers in the following cycle with a range status.
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_FREE && 32'(page_index) >= NUM_PAGES)
        |=> (done && status == STAT_RANGE && !busy))
        else $error("out-of-range free not rejected");

    // No result is issued while the sequencer is still working on a request.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while busy");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the page run allocator top level.
// Depends on pra_pkg and page_run_allocator_top from the hdl folder.
`timescale 1ns / 100ps

module tb_top;
    import pra_pkg::*;

    localparam int PAGES    = DEF_NUM_PAGES;
    localparam int RESERVED = DEF_RESERVED_PAGES;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIRST_W-1:0]  first_page;
    } outcome_t;

    // The ledger keeps a private copy of the page marks and the search window.
    // It works out the outcome of every accepted request beat, queues it, and
    // compares each result beat from the block against the oldest outcome.
    class page_ledger;
        logic [MARK_W-1:0] marks [PAGES];
        logic [CFG_W-1:0]  window;
        outcome_t          awaited [$];
        int                failures;

        function new();
            for (int pg = 0; pg < PAGES; pg++)
                marks[pg] = '0;
            for (int pg = 0; pg < RESERVED; pg++)
                marks[pg][MARK_TAKEN_BIT] = 1'b1;
            marks[RESERVED - 1][MARK_LAST_BIT] = 1'b1;
            window   = CFG_W'(PAGES / 10);
            failures = 0;
        endfunction

        function void set_window(logic [CFG_W-1:0] value);
            window = value;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function bit page_held(int pg);
            return marks[pg][MARK_TAKEN_BIT];
        endfunction

        function int taken_count();
            int total;
            total = 0;
            for (int pg = 0; pg < PAGES; pg++)
                total += int'(page_held(pg));
            return total;
        endfunction

        // First fit over start pages below the window. A short free stretch
        // is skipped whole, since no start inside it can succeed either.
        function outcome_t grant_run(logic [COUNT_W-1:0] count);
            outcome_t res;
            int       need;
            int       span;
            int       pos;
            int       len;
            bit       hit;
            need = (count == '0) ? 1 : int'(count);
            span = (int'(window) > PAGES) ? PAGES : int'(window);
            pos  = 0;
            hit  = 1'b0;
            while (pos < span && !hit)
            begin
                if (page_held(pos))
                    pos++;
                else
                begin
                    len = 0;
                    while (pos + len < PAGES && !page_held(pos + len) && len < need)
                        len++;
                    if (len >= need)
                        hit = 1'b1;
                    else
                        pos += len;
                end
            end
            res.status     = STAT_NOSPACE;
            res.first_page = '0;
            if (hit)
            begin
                for (int k = 0; k < need; k++)
                    marks[pos + k][MARK_TAKEN_BIT] = 1'b1;
                marks[pos + need - 1][MARK_LAST_BIT] = 1'b1;
                res.status     = STAT_OK;
                res.first_page = FIRST_W'(pos);
            end
            return res;
        endfunction

        // Closes the run in front of the page, then clears up to and including
        // the next last-marked page. Pages cleared before a double free stay
        // cleared.
        function outcome_t release_run(logic [INDEX_W-1:0] index);
            outcome_t res;
            int       loc;
            loc            = int'(index);
            res.status     = STAT_OK;
            res.first_page = '0;
            if (loc >= PAGES)
                res.status = STAT_RANGE;
            else if (loc < RESERVED)
                res.status = STAT_RESERVED;
            else
            begin
                if (page_held(loc - 1))
                    marks[loc - 1][MARK_LAST_BIT] = 1'b1;
                while (loc < PAGES)
                begin
                    if (!page_held(loc))
                    begin
                        res.status = STAT_DOUBLE;
                        break;
                    end
                    if (marks[loc][MARK_LAST_BIT])
                    begin
                        marks[loc] = '0;
                        break;
                    end
                    marks[loc][MARK_TAKEN_BIT] = 1'b0;
                    loc++;
                end
            end
            return res;
        endfunction

        function void note_request(logic kind, logic [COUNT_W-1:0] count,
                                   logic [INDEX_W-1:0] index);
            if (kind == REQ_ALLOC)
                awaited.push_back(grant_run(count));
            else
                awaited.push_back(release_run(index));
        endfunction

        function void check_result(logic [STATUS_W-1:0] seen_status,
                                   logic [FIRST_W-1:0] seen_page);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                $error("result beat with no request outstanding: status %0d, first_page %0d",
                       seen_status, seen_page);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (seen_status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, seen_status);
                failures++;
            end
            if (seen_page !== want.first_page)
            begin
                $error("first_page mismatch: expected %0d, actual %0d",
                       want.first_page, seen_page);
                failures++;
            end
        endfunction

        // Picks a taken page at random, or only pages that begin a run. Gives
        // -1 when there is no such page.
        function int pick_page(bit starts_only);
            int spots [$];
            for (int pg = RESERVED; pg < PAGES; pg++)
                if (page_held(pg) && (!starts_only || !page_held(pg - 1) ||
                                      marks[pg - 1][MARK_LAST_BIT]))
                    spots.push_back(pg);
            if (spots.size() == 0)
                return -1;
            return spots[$urandom_range(spots.size() - 1)];
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  req_type;
    logic [COUNT_W-1:0]    page_count;
    logic [INDEX_W-1:0]    page_index;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [FIRST_W-1:0]    first_page;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    page_ledger ledger = new();
    int         sent   = 0;

    page_run_allocator_top #(
        .NUM_PAGES      (PAGES),
        .RESERVED_PAGES (RESERVED)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .page_count (page_count),
        .page_index (page_index),
        .done       (done),
        .status     (status),
        .first_page (first_page),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Every result beat lives for exactly one cycle and cannot be held off,
    // so it is taken at each rising edge where done was high.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            ledger.check_result(status, first_page);
    end

    // Sends one request beat. The sender idles at random before raising
    // start: a quarter of the cycles for the first stretch of the run, about
    // half for the second, never for the rest. start stays high while the
    // block is busy, and the beat counts as taken at the first edge where busy
    // was low. On return start is still high, so the next beat either follows
    // at once or lowers it in the same step.
    task automatic issue(input logic kind, input logic [COUNT_W-1:0] count,
                         input logic [INDEX_W-1:0] index);
        int pct;
        pct = (sent < 430) ? 25 : (sent < 860) ? 48 : 0;
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < pct);
        end
        start      <= 1'b1;
        req_type   <= kind;
        page_count <= count;
        page_index <= index;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        ledger.note_request(kind, count, index);
        sent++;
    endtask

    // Drops start and holds off until every outstanding result beat is in.
    // Since done comes in the cycle that busy falls, the block is idle then.
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (ledger.outstanding() != 0);
    endtask

    // Writes the search window in a setup and an access phase. The unused upper
    // data bits carry noise; only the low bits of the register matter.
    task automatic write_search_starts(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SEARCH_STARTS;
        pwdata  <= {(APB_DATA_W - CFG_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        ledger.set_window(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic that mostly forms real alloc and free pairs. Allocation
    // wins more often while the store is lightly used, which keeps occupancy
    // and therefore the scan length bounded. Most counts are small; a few
    // span the whole field so that oversized requests show up. Frees go
    // mostly to run starts, some to pages inside a run, some anywhere (which
    // tends to give double frees) and a few to the reserved page.
    task automatic random_request();
        int                 roll;
        int                 pg;
        logic [COUNT_W-1:0] count;
        roll = $urandom_range(99);
        if (roll < ((ledger.taken_count() < 250) ? 60 : 25))
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                count = COUNT_W'($urandom_range(8));
            else if (roll < 90)
                count = COUNT_W'($urandom_range(64, 9));
            else if (roll < 97)
                count = COUNT_W'($urandom_range(300, 65));
            else
                count = COUNT_W'($urandom);
            issue(REQ_ALLOC, count, INDEX_W'($urandom));
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < 75)
                pg = ledger.pick_page(1'b1);
            else if (roll < 87)
                pg = ledger.pick_page(1'b0);
            else if (roll < 95)
                pg = $urandom_range(PAGES - 1);
            else
                pg = 0;
            if (pg < 0)
                pg = $urandom_range(PAGES - 1);
            issue(REQ_FREE, COUNT_W'($urandom), INDEX_W'(pg));
        end
        // Now and then the sender waits for the block to drain completely.
        if ($urandom_range(63) == 0)
            settle();
    endtask

    initial
    begin
        int phase_window [10];
        int phase_items [10];

        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= REQ_ALLOC;
        page_count <= '0;
        page_index <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset window. The first beat waits out the
        // clearing pass, since busy stays high through it.
        issue(REQ_FREE,  11'h7FF, 10'd0);       // the reserved page
        issue(REQ_ALLOC, 11'd0,   10'h3FF);     // zero count acts as one
        issue(REQ_ALLOC, 11'd1,   10'd0);
        issue(REQ_ALLOC, 11'd5,   10'd0);
        issue(REQ_FREE,  11'd0,   10'd2);       // a one-page run
        issue(REQ_FREE,  11'd0,   10'd2);       // the same page again
        issue(REQ_FREE,  11'd0,   10'd5);       // inside a run: splits it
        issue(REQ_FREE,  11'd0,   10'd3);       // the front half left behind
        issue(REQ_ALLOC, 11'd1024, 10'd0);      // larger than any free run
        issue(REQ_ALLOC, 11'h7FF, 10'd0);       // count field all ones
        issue(REQ_FREE,  11'd0,   10'h3FF);     // last page, never taken
        issue(REQ_ALLOC, 11'd200, 10'd0);       // starts in the window, ends past it
        issue(REQ_ALLOC, 11'd98,  10'd0);
        issue(REQ_ALLOC, 11'd1,   10'd0);
        issue(REQ_FREE,  11'd0,   10'd1);
        issue(REQ_FREE,  11'd0,   10'd100);     // deep inside the long run
        issue(REQ_ALLOC, 11'd1023, 10'd0);
        issue(REQ_ALLOC, 11'h555, 10'h2AA);
        issue(REQ_FREE,  11'h2AA, 10'h2AA);
        issue(REQ_FREE,  11'h555, 10'h155);

        // Random phases, each under its own window. Zero scans nothing, one
        // covers only the reserved page, and values past the store scan it
        // all. The last phase puts the reset value back.
        phase_window = '{int'($urandom_range(1023, 3)), 0, 2047, 1024, 2, 1,
                         int'($urandom_range(1023, 3)), 512,
                         int'($urandom_range(1023, 3)), 102};
        phase_items  = '{150, 40, 170, 150, 60, 40, 170, 150, 170, 150};
        for (int ph = 0; ph < 10; ph++)
        begin
            settle();
            write_search_starts(CFG_W'(phase_window[ph]));
            repeat (phase_items[ph]) random_request();
        end

        // Drain, then give a stray beat some cycles to show itself.
        settle();
        repeat (16) @(posedge clk);
        if (ledger.failures == 0 && ledger.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // A hung handshake ends the run here. The bound allows every beat the
    // longest scan plus the clearing pass, several times over.
    initial
    begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pra_pkg.sv
hdl/pra_mark_mem.sv
hdl/pra_ctrl.sv
hdl/page_run_allocator_top.sv
dv/tb_top.sv
